/* rtl/wfsa_pkg.sv */
`timescale 1ns / 1ps
package wfsa_pkg;

   localparam int unsigned DATA_W = 31;
   localparam int unsigned REF_W  = 10;
   localparam int unsigned STAT_W = 2;

   typedef enum logic [STAT_W-1:0] {
      STAT_GRANT = 2'd0,
      STAT_NOFIT = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_H_RD,
      ST_F_CUR,
      ST_F_PREV,
      ST_F_NEXT,
      ST_F_NN,
      ST_F_BUILD,
      ST_SCAN,
      ST_S_TAIL,
      ST_PICK,
      ST_A_PRV,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

/* rtl/worst_fit_segment_allocator_core.sv */
`timescale 1ns / 1ps
// Worst-fit segment allocator over a linear space of csr_total_size cells.
// Request channel (req_*): req_action 0 allocates req_alloc_size cells,
// 1 releases the block granted to arrival number req_free_ref. Every word
// taken while fewer than MAX_ITEMS have arrived gets an arrival number.
// Response channel (rsp_*): one word per allocate, none per release.
// rsp_status 0 grants at 1-based rsp_start_address, 1 means no free segment
// fits, 2 means the handle capacity is used up.
// A release holds req_stall high until it is done. An allocate that splits a
// segment, an exact fit and a miss each answer after the scan of the segment
// memory through its single read port to find the longest free segment. A
// zero-size or over-capacity allocate answers without a scan.
// One word is worked at a time; req_stall is high while a word is in progress.
// Reset and each csr write run a clearing pass over both memories, leaving
// one free segment; requests stall meanwhile. A stalled response holds in
// the output register; the next request is taken while it waits, and a new
// response waits for it to drain.
module worst_fit_segment_allocator_core #(
   parameter int unsigned MAX_ITEMS    = 1024,
   parameter int unsigned MAX_SEGMENTS = 1025
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [wfsa_pkg::DATA_W-1:0]       req_alloc_size,
   input  logic [wfsa_pkg::REF_W-1:0]        req_free_ref,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wfsa_pkg::STAT_W-1:0]       rsp_status,
   output logic [wfsa_pkg::DATA_W-1:0]       rsp_start_address,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wfsa_pkg::DATA_W-1:0]       csr_total_size
);

   localparam int unsigned SW    = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned SAW   = $clog2(MAX_SEGMENTS);
   localparam int unsigned IW    = $clog2(MAX_ITEMS);
   localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
   localparam int unsigned CLR_N = (MAX_SEGMENTS > MAX_ITEMS) ? MAX_SEGMENTS : MAX_ITEMS;
   localparam int unsigned KW    = $clog2(CLR_N + 1);
   localparam int unsigned DW    = wfsa_pkg::DATA_W;
   localparam logic [SW-1:0] SEG_NONE = SW'(MAX_SEGMENTS);

   typedef struct packed {
      logic          used;
      logic          free;
      logic [DW-1:0] start;
      logic [DW-1:0] len;
      logic [SW-1:0] prev;
      logic [SW-1:0] next;
   } seg_type;

   typedef struct packed {
      logic          vld;
      logic [SW-1:0] slot;
   } hnd_type;

   localparam seg_type SEG_EMPTY = '{used: 1'b0, free: 1'b0, start: '0, len: '0,
                                     prev: SEG_NONE, next: SEG_NONE};

   function automatic logic [SAW-1:0] slot_addr(input logic [SW-1:0] s);
      logic [SAW-1:0] a;
      a = '0;
      if (s < SEG_NONE) begin
         a = s[SAW-1:0];
      end
      return a;
   endfunction

   seg_type seg_mem [MAX_SEGMENTS];
   hnd_type hnd_mem [MAX_ITEMS];

   wfsa_pkg::state_type state_ff, state_in;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [DW-1:0]        rsp_addr_ff;
   logic [CW-1:0]        count_ff;
   logic [DW-1:0]        total_ff;
   logic [KW-1:0]        clr_ff;

   logic                 action_ff;
   logic [DW-1:0]        size_ff;
   logic [IW-1:0]        ref_ff;
   logic [IW-1:0]        item_ff;
   wfsa_pkg::status_type pend_status_ff;
   logic [DW-1:0]        pend_addr_ff;

   seg_type              cur_ff, p_ff, n_ff, nn_ff, best_ff;
   logic [SW-1:0]        cur_idx_ff, best_idx_ff, unused_idx_ff, scan_d_ff;
   logic [SW-1:0]        scan_ff;
   logic                 scan_vld_ff, best_vld_ff, unused_vld_ff;
   logic                 pf_ff, nf_ff;
   logic [DW-1:0]        sum_ff;

   logic [3:0]           wq_en_ff;
   logic [SAW-1:0]       wq_addr_ff [4];
   seg_type              wq_data_ff [4];
   logic [1:0]           wq_ptr_ff;

   logic [3:0]           bq_en;
   logic [SAW-1:0]       bq_addr [4];
   seg_type              bq_data [4];
   logic                 bq_load;

   seg_type              rd_data;
   hnd_type              h_rdata;
   logic [SAW-1:0]       rd_addr;
   logic                 seg_we;
   logic [SAW-1:0]       seg_waddr;
   seg_type              seg_wdata;
   logic                 h_we;
   logic [IW-1:0]        h_waddr, h_raddr;
   hnd_type              h_wdata;

   logic                 req_accept, csr_accept, rsp_load, full;
   logic                 pf, nf, in_range;

   assign req_accept = req_valid && !req_stall;
   assign csr_accept = csr_valid && csr_ready;
   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != wfsa_pkg::ST_IDLE);
   assign full       = (count_ff == CW'(MAX_ITEMS));
   assign in_range   = (32'(req_free_ref) < 32'(MAX_ITEMS));
   assign rsp_load   = (state_ff == wfsa_pkg::ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign pf         = (cur_ff.prev != SEG_NONE) && p_ff.free;
   assign nf         = (cur_ff.next != SEG_NONE) && rd_data.free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_start_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_waddr] <= seg_wdata;
      end
      rd_data <= seg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         hnd_mem[h_waddr] <= h_wdata;
      end
      h_rdata <= hnd_mem[h_raddr];
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      rd_addr   = '0;
      seg_we    = 1'b0;
      seg_waddr = wq_addr_ff[wq_ptr_ff];
      seg_wdata = wq_data_ff[wq_ptr_ff];
      h_we      = 1'b0;
      h_waddr   = ref_ff;
      h_wdata   = '{vld: 1'b0, slot: SEG_NONE};
      h_raddr   = IW'(32'(req_free_ref));
      unique case (state_ff)
         wfsa_pkg::ST_CLEAR: begin
            seg_we    = (32'(clr_ff) < 32'(MAX_SEGMENTS));
            seg_waddr = clr_ff[SAW-1:0];
            seg_wdata = SEG_EMPTY;
            if (clr_ff == '0) begin
               seg_wdata.used = 1'b1;
               seg_wdata.free = 1'b1;
               seg_wdata.len  = total_ff;
            end
            h_we    = (32'(clr_ff) < 32'(MAX_ITEMS));
            h_waddr = clr_ff[IW-1:0];
            if (clr_ff == KW'(CLR_N - 1)) begin
               state_in = wfsa_pkg::ST_IDLE;
            end
         end
         wfsa_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (full) begin
                  state_in = req_action ? wfsa_pkg::ST_IDLE : wfsa_pkg::ST_RESP;
               end else if (req_action) begin
                  state_in = in_range ? wfsa_pkg::ST_H_RD : wfsa_pkg::ST_IDLE;
               end else begin
                  state_in = (req_alloc_size == '0) ? wfsa_pkg::ST_RESP : wfsa_pkg::ST_SCAN;
               end
            end
         end
         wfsa_pkg::ST_H_RD: begin
            h_we    = 1'b1;
            rd_addr = slot_addr(h_rdata.slot);
            state_in = h_rdata.vld ? wfsa_pkg::ST_F_CUR : wfsa_pkg::ST_IDLE;
         end
         wfsa_pkg::ST_F_CUR: begin
            rd_addr  = slot_addr(rd_data.prev);
            state_in = (rd_data.used && !rd_data.free) ? wfsa_pkg::ST_F_PREV
                                                       : wfsa_pkg::ST_IDLE;
         end
         wfsa_pkg::ST_F_PREV: begin
            rd_addr  = slot_addr(cur_ff.next);
            state_in = wfsa_pkg::ST_F_NEXT;
         end
         wfsa_pkg::ST_F_NEXT: begin
            rd_addr  = slot_addr(rd_data.next);
            state_in = (pf && nf) ? wfsa_pkg::ST_F_NN : wfsa_pkg::ST_F_BUILD;
         end
         wfsa_pkg::ST_F_NN: begin
            state_in = wfsa_pkg::ST_F_BUILD;
         end
         wfsa_pkg::ST_F_BUILD: begin
            state_in = wfsa_pkg::ST_WRITE;
         end
         wfsa_pkg::ST_SCAN: begin
            rd_addr = scan_ff[SAW-1:0];
            if (scan_ff == SW'(MAX_SEGMENTS - 1)) begin
               state_in = wfsa_pkg::ST_S_TAIL;
            end
         end
         wfsa_pkg::ST_S_TAIL: begin
            state_in = wfsa_pkg::ST_PICK;
         end
         wfsa_pkg::ST_PICK: begin
            h_waddr = item_ff;
            h_wdata = '{vld: 1'b1, slot: best_idx_ff};
            rd_addr = slot_addr(best_ff.prev);
            if (!best_vld_ff || best_ff.len < size_ff) begin
               state_in = wfsa_pkg::ST_RESP;
            end else if (best_ff.len == size_ff) begin
               h_we     = 1'b1;
               state_in = wfsa_pkg::ST_WRITE;
            end else if (!unused_vld_ff) begin
               state_in = wfsa_pkg::ST_RESP;
            end else begin
               state_in = wfsa_pkg::ST_A_PRV;
            end
         end
         wfsa_pkg::ST_A_PRV: begin
            h_we     = 1'b1;
            h_waddr  = item_ff;
            h_wdata  = '{vld: 1'b1, slot: unused_idx_ff};
            state_in = wfsa_pkg::ST_WRITE;
         end
         wfsa_pkg::ST_WRITE: begin
            seg_we = wq_en_ff[wq_ptr_ff];
            if (wq_ptr_ff == 2'd3) begin
               state_in = action_ff ? wfsa_pkg::ST_IDLE : wfsa_pkg::ST_RESP;
            end
         end
         wfsa_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = wfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfsa_pkg::ST_IDLE;
         end
      endcase
      if (reset || csr_accept) begin
         state_in = wfsa_pkg::ST_CLEAR;
      end
   end

   always_comb begin
      bq_load = 1'b0;
      bq_en   = '0;
      for (int i = 0; i < 4; i++) begin
         bq_addr[i] = '0;
         bq_data[i] = SEG_EMPTY;
      end
      unique case (state_ff)
         wfsa_pkg::ST_F_BUILD: begin
            bq_load    = 1'b1;
            bq_en[2]   = pf_ff || nf_ff;
            bq_addr[2] = slot_addr(cur_idx_ff);
            priority if (pf_ff && nf_ff) begin
               bq_en[0]        = 1'b1;
               bq_addr[0]      = slot_addr(cur_ff.prev);
               bq_data[0]      = p_ff;
               bq_data[0].len  = p_ff.len + sum_ff;
               bq_data[0].next = n_ff.next;
               bq_en[1]        = (n_ff.next != SEG_NONE);
               bq_addr[1]      = slot_addr(n_ff.next);
               bq_data[1]      = nn_ff;
               bq_data[1].prev = cur_ff.prev;
               bq_en[3]        = 1'b1;
               bq_addr[3]      = slot_addr(cur_ff.next);
            end else if (pf_ff) begin
               bq_en[0]        = 1'b1;
               bq_addr[0]      = slot_addr(cur_ff.prev);
               bq_data[0]      = p_ff;
               bq_data[0].len  = p_ff.len + sum_ff;
               bq_data[0].next = cur_ff.next;
               bq_en[1]        = (cur_ff.next != SEG_NONE);
               bq_addr[1]      = slot_addr(cur_ff.next);
               bq_data[1]      = n_ff;
               bq_data[1].prev = cur_ff.prev;
               bq_en[2]        = 1'b1;
            end else if (nf_ff) begin
               bq_en[0]         = 1'b1;
               bq_addr[0]       = slot_addr(cur_ff.next);
               bq_data[0]       = n_ff;
               bq_data[0].start = cur_ff.start;
               bq_data[0].len   = sum_ff;
               bq_data[0].prev  = cur_ff.prev;
               bq_en[1]         = (cur_ff.prev != SEG_NONE);
               bq_addr[1]       = slot_addr(cur_ff.prev);
               bq_data[1]       = p_ff;
               bq_data[1].next  = cur_ff.next;
               bq_en[2]         = 1'b1;
            end else begin
               bq_en[0]        = 1'b1;
               bq_addr[0]      = slot_addr(cur_idx_ff);
               bq_data[0]      = cur_ff;
               bq_data[0].free = 1'b1;
               bq_en[2]        = 1'b0;
            end
         end
         wfsa_pkg::ST_PICK: begin
            bq_load         = 1'b1;
            bq_en[0]        = 1'b1;
            bq_addr[0]      = slot_addr(best_idx_ff);
            bq_data[0]      = best_ff;
            bq_data[0].free = 1'b0;
         end
         wfsa_pkg::ST_A_PRV: begin
            bq_load          = 1'b1;
            bq_en[0]         = 1'b1;
            bq_addr[0]       = slot_addr(unused_idx_ff);
            bq_data[0]       = '{used: 1'b1, free: 1'b0, start: best_ff.start, len: size_ff,
                                 prev: best_ff.prev, next: best_idx_ff};
            bq_en[1]         = 1'b1;
            bq_addr[1]       = slot_addr(best_idx_ff);
            bq_data[1]       = best_ff;
            bq_data[1].start = best_ff.start + size_ff;
            bq_data[1].len   = best_ff.len - size_ff;
            bq_data[1].prev  = unused_idx_ff;
            bq_en[2]         = (best_ff.prev != SEG_NONE);
            bq_addr[2]       = slot_addr(best_ff.prev);
            bq_data[2]       = rd_data;
            bq_data[2].next  = unused_idx_ff;
         end
         default: begin
            bq_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         total_ff     <= DW'(1);
         clr_ff       <= '0;
         wq_ptr_ff    <= '0;
         scan_vld_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_accept) begin
            total_ff <= csr_total_size;
            count_ff <= '0;
            clr_ff   <= '0;
         end else begin
            if (state_ff == wfsa_pkg::ST_CLEAR) begin
               clr_ff <= clr_ff + 1'b1;
            end else begin
               clr_ff <= '0;
            end
            if (req_accept && !full) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (bq_load) begin
            wq_ptr_ff <= '0;
         end else if (state_ff == wfsa_pkg::ST_WRITE) begin
            wq_ptr_ff <= wq_ptr_ff + 1'b1;
         end
         scan_vld_ff <= (state_ff == wfsa_pkg::ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_addr_ff   <= pend_addr_ff;
      end
      if (bq_load) begin
         wq_en_ff <= bq_en;
         for (int i = 0; i < 4; i++) begin
            wq_addr_ff[i] <= bq_addr[i];
            wq_data_ff[i] <= bq_data[i];
         end
      end
      if (scan_vld_ff) begin
         if (rd_data.used && rd_data.free &&
             (!best_vld_ff || rd_data.len > best_ff.len ||
              (rd_data.len == best_ff.len && rd_data.start < best_ff.start))) begin
            best_vld_ff <= 1'b1;
            best_ff     <= rd_data;
            best_idx_ff <= scan_d_ff;
         end
         if (!rd_data.used && !unused_vld_ff) begin
            unused_vld_ff <= 1'b1;
            unused_idx_ff <= scan_d_ff;
         end
      end
      unique case (state_ff)
         wfsa_pkg::ST_IDLE: begin
            action_ff      <= req_action;
            size_ff        <= req_alloc_size;
            ref_ff         <= IW'(32'(req_free_ref));
            item_ff        <= count_ff[IW-1:0];
            pend_status_ff <= full ? wfsa_pkg::STAT_FULL : wfsa_pkg::STAT_NOFIT;
            pend_addr_ff   <= '0;
            best_vld_ff    <= 1'b0;
            unused_vld_ff  <= 1'b0;
            scan_ff        <= '0;
         end
         wfsa_pkg::ST_H_RD: begin
            cur_idx_ff <= h_rdata.slot;
         end
         wfsa_pkg::ST_F_CUR: begin
            cur_ff <= rd_data;
         end
         wfsa_pkg::ST_F_PREV: begin
            p_ff <= rd_data;
         end
         wfsa_pkg::ST_F_NEXT: begin
            n_ff   <= rd_data;
            pf_ff  <= pf;
            nf_ff  <= nf;
            sum_ff <= cur_ff.len + (nf ? rd_data.len : DW'(0));
         end
         wfsa_pkg::ST_F_NN: begin
            nn_ff <= rd_data;
         end
         wfsa_pkg::ST_SCAN: begin
            scan_ff   <= scan_ff + 1'b1;
            scan_d_ff <= scan_ff;
         end
         wfsa_pkg::ST_PICK: begin
            if (best_vld_ff && best_ff.len == size_ff) begin
               pend_status_ff <= wfsa_pkg::STAT_GRANT;
               pend_addr_ff   <= best_ff.start + DW'(1);
            end
         end
         wfsa_pkg::ST_A_PRV: begin
            pend_status_ff <= wfsa_pkg::STAT_GRANT;
            pend_addr_ff   <= best_ff.start + DW'(1);
         end
         default: begin
            scan_d_ff <= scan_d_ff;
         end
      endcase
   end

endmodule

/* bench/worst_fit_segment_allocator_core_test.sv */
`timescale 1ns / 1ps
module worst_fit_segment_allocator_core_test;

   localparam int NITEM = 1024;
   localparam int NSEG  = 1025;
   localparam int NONE  = 1025;
   localparam bit ACT_ALLOC = 1'b0;
   localparam bit ACT_FREE  = 1'b1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;

   typedef enum logic [0:0] { ROW_WORD, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 action;
      logic [30:0]          size;
      logic [9:0]           ref_no;
      logic                 typed;
      wfsa_pkg::status_type st;
      logic [30:0]          addr;
   } row_type;

   typedef struct packed {
      wfsa_pkg::status_type st;
      logic [30:0]          addr;
   } grant_word_type;

   localparam int NROWS = 31;
   localparam row_type DIRECTED [NROWS] = '{
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd1},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd0, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd1},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd1023, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd9, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd2, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_CSR,  ACT_ALLOC, 31'd0, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, SIZE_MAX, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_CSR,  ACT_ALLOC, SIZE_MAX, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, SIZE_MAX, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd1},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b1, wfsa_pkg::STAT_NOFIT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, SIZE_MAX, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd1},
      '{ROW_CSR,  ACT_ALLOC, 31'd100, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd10, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd1},
      '{ROW_WORD, ACT_ALLOC, 31'd20, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd11},
      '{ROW_WORD, ACT_ALLOC, 31'd30, 10'd0, 1'b1, wfsa_pkg::STAT_GRANT, 31'd31},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd1, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd40, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd30, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd35, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd6, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_FREE,  31'd0, 10'd2, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd100, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0},
      '{ROW_WORD, ACT_ALLOC, 31'd1, 10'd0, 1'b0, wfsa_pkg::STAT_GRANT, 31'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [30:0] req_alloc_size = '0;
   logic [9:0]  req_free_ref = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_start_address;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_total_size = '0;

   worst_fit_segment_allocator_core #(
      .MAX_ITEMS(NITEM), .MAX_SEGMENTS(NSEG)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_alloc_size(req_alloc_size), .req_free_ref(req_free_ref),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_start_address(rsp_start_address),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_total_size(csr_total_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // allocator mirror
   logic [30:0] m_start [NSEG];
   logic [30:0] m_len   [NSEG];
   bit          m_free  [NSEG];
   bit          m_used  [NSEG];
   int          m_prev  [NSEG];
   int          m_next  [NSEG];
   int          m_handle [NITEM];
   int          m_items;
   logic [30:0] m_total;

   grant_word_type pending_grants [$];
   int             live_items [$];
   int  errors = 0;
   int  n_grant = 0, n_nofit = 0, n_full = 0, n_free = 0;
   bit  calm = 1'b0;
   bit  hold_request = 1'b0;
   bit  hold_armed = 1'b0;

   function automatic void grant_append(input grant_word_type w);
      pending_grants = {pending_grants, w};
   endfunction

   function automatic void live_append(input int item);
      live_items = {live_items, item};
   endfunction

   function automatic void mirror_clear();
      for (int i = 0; i < NSEG; i++) begin
         m_start[i] = '0; m_len[i] = '0; m_free[i] = 0; m_used[i] = 0;
         m_prev[i] = NONE; m_next[i] = NONE;
      end
      for (int i = 0; i < NITEM; i++) m_handle[i] = NONE;
      m_used[0] = 1; m_free[0] = 1; m_len[0] = m_total;
      m_items = 0;
      live_items.delete();
   endfunction

   function automatic void drop_slot(int s);
      int p, n;
      p = m_prev[s];
      n = m_next[s];
      if (p < NONE) m_next[p] = n;
      if (n < NONE) m_prev[n] = p;
      m_prev[s] = NONE; m_next[s] = NONE;
      m_used[s] = 0; m_free[s] = 0; m_start[s] = '0; m_len[s] = '0;
   endfunction

   function automatic void merge_free(int c);
      int p, n;
      bit pf, nf;
      p = m_prev[c];
      n = m_next[c];
      pf = p < NONE && m_free[p];
      nf = n < NONE && m_free[n];
      if (pf && nf) begin
         m_len[p] = m_len[p] + m_len[c] + m_len[n];
         drop_slot(n);
         drop_slot(c);
      end else if (pf) begin
         m_len[p] = m_len[p] + m_len[c];
         drop_slot(c);
      end else if (nf) begin
         m_start[n] = m_start[c];
         m_len[n] = m_len[n] + m_len[c];
         drop_slot(c);
      end else begin
         m_free[c] = 1;
      end
   endfunction

   function automatic void mirror_word(input bit act, input logic [30:0] sz,
                                       input logic [9:0] rf, output bit has,
                                       output grant_word_type w);
      int item, b, s;
      has = 0;
      w.st = wfsa_pkg::STAT_NOFIT;
      w.addr = '0;
      if (m_items >= NITEM) begin
         if (act == ACT_FREE) return;
         has = 1;
         w.st = wfsa_pkg::STAT_FULL;
         return;
      end
      item = m_items;
      m_items++;
      if (act == ACT_FREE) begin
         s = m_handle[rf];
         m_handle[rf] = NONE;
         if (s < NONE && m_used[s] && !m_free[s]) merge_free(s);
         return;
      end
      has = 1;
      if (sz == 0) return;
      b = NONE;
      for (int i = 0; i < NSEG; i++) begin
         if (!m_used[i] || !m_free[i]) continue;
         if (b == NONE || m_len[i] > m_len[b] ||
             (m_len[i] == m_len[b] && m_start[i] < m_start[b]))
            b = i;
      end
      if (b == NONE || m_len[b] < sz) return;
      if (m_len[b] == sz) begin
         m_free[b] = 0;
         s = b;
      end else begin
         s = NONE;
         for (int i = 0; i < NSEG; i++)
            if (!m_used[i]) begin
               s = i;
               break;
            end
         if (s == NONE) return;
         m_used[s] = 1; m_free[s] = 0;
         m_start[s] = m_start[b]; m_len[s] = sz;
         m_prev[s] = m_prev[b]; m_next[s] = b;
         if (m_prev[b] < NONE) m_next[m_prev[b]] = s;
         m_prev[b] = s;
         m_start[b] = m_start[b] + sz;
         m_len[b] = m_len[b] - sz;
      end
      m_handle[item] = s;
      live_append(item);
      w.st = wfsa_pkg::STAT_GRANT;
      w.addr = m_start[s] + 31'd1;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_word(input bit act, input logic [30:0] sz, input logic [9:0] rf,
                            input bit typed, input grant_word_type typed_w);
      bit has;
      grant_word_type w;
      int g;
      req_valid = 1'b1;
      req_action = act;
      req_alloc_size = sz;
      req_free_ref = rf;
      do @(posedge clock); while (req_stall);
      mirror_word(act, sz, rf, has, w);
      if (act == ACT_FREE) n_free++;
      if (has) grant_append(typed ? typed_w : w);
      @(negedge clock);
      g = calm ? 0 : gap_len();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_drained(input int extra);
      req_valid = 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_total(input logic [30:0] value);
      wait_drained(30);
      csr_valid = 1'b1;
      csr_total_size = value;
      do @(posedge clock); while (!csr_ready);
      m_total = value;
      mirror_clear();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [30:0] pick_size(logic [30:0] total);
      int r;
      logic [30:0] span;
      r = $urandom_range(0, 99);
      span = (total / 6 > 0) ? total / 6 : 31'd1;
      if (r < 70) return 31'($urandom_range(1, span));
      if (r < 82) return 31'($urandom_range(1, total > 0 ? total : 1));
      if (r < 92) return 31'($urandom());
      if (r < 96) return total;
      return '0;
   endfunction

   task automatic random_phase(input logic [30:0] total, input int count);
      int r, k;
      grant_word_type dummy;
      dummy = '0;
      write_total(total);
      for (int i = 0; i < count; i++) begin
         if (hold_armed && i == 4) begin
            hold_request = 1'b1;
            hold_armed = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (live_items.size() != 0 && r < 38) begin
            k = $urandom_range(0, live_items.size() - 1);
            send_word(ACT_FREE, 31'($urandom()), 10'(live_items[k]), 1'b0, dummy);
            live_items.delete(k);
         end else if (r < 46) begin
            send_word(ACT_FREE, 31'($urandom()), 10'($urandom()), 1'b0, dummy);
         end else begin
            send_word(ACT_ALLOC, pick_size(total), 10'($urandom()), 1'b0, dummy);
         end
      end
   endtask

   // response side
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_request) begin
         rsp_stall = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_request = 1'b0;
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
   end

   always @(posedge clock) begin
      grant_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected response status=%0d addr=%0d",
                     $time, rsp_status, rsp_start_address);
            errors++;
         end else begin
            w = pending_grants.pop_front();
            if (rsp_status !== w.st) begin
               $display("%0t: status expected %0d actual %0d", $time, w.st, rsp_status);
               errors++;
            end
            if (rsp_start_address !== w.addr) begin
               $display("%0t: start_address expected %0d actual %0d",
                        $time, w.addr, rsp_start_address);
               errors++;
            end
            case (w.st)
               wfsa_pkg::STAT_GRANT: n_grant++;
               wfsa_pkg::STAT_NOFIT: n_nofit++;
               default: n_full++;
            endcase
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      grant_word_type tw;
      grant_word_type dummy;
      dummy = '0;
      m_total = 31'd1;
      mirror_clear();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            write_total(DIRECTED[i].size);
         end else begin
            tw.st = DIRECTED[i].st;
            tw.addr = DIRECTED[i].addr;
            send_word(DIRECTED[i].action, DIRECTED[i].size, DIRECTED[i].ref_no,
                      DIRECTED[i].typed, tw);
         end
      end

      hold_armed = 1'b1;
      random_phase(31'd1000, 150);
      calm = 1'b1;
      random_phase(31'd64, 100);
      calm = 1'b0;
      random_phase(SIZE_MAX, 150);
      random_phase(31'd5000, 150);
      random_phase(31'd1, 60);
      random_phase(31'd300, 120);

      // run the arrival numbers out, then keep sending past capacity
      write_total(31'd50);
      for (int i = 0; i < 1040; i++) begin
         if (i < 12 || i >= NITEM - 4)
            send_word(1'($urandom()), pick_size(31'd50), 10'($urandom()), 1'b0, dummy);
         else
            send_word(ACT_FREE, 31'($urandom()), 10'($urandom()), 1'b0, dummy);
      end

      wait_drained(60);
      $display("Covered %0d grants, %0d no-fit, %0d capacity refusals, %0d releases",
               n_grant, n_nofit, n_full, n_free);
      $display("over a range of memory sizes including zero, one and the 31-bit maximum.");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
